### design/kal1d_pkg.sv
// Shared widths, register indexes and reset values of the velocity-aided
// scalar Kalman filter.
// Depends on nothing; every other design file but kal1d_mul imports it.
package kal1d_pkg;

   localparam int DATA_W    = 32;
   localparam int PERIOD_W  = 10;
   localparam int GAIN_W    = 16;
   localparam int MAG_W     = DATA_W + 1;
   localparam int CSR_IDX_W = 2;

   // Product widths of the three serial multiplies.
   localparam int DPROD_W = MAG_W + PERIOD_W;
   localparam int CPROD_W = MAG_W + GAIN_W;
   localparam int PPROD_W = DATA_W + GAIN_W + 1;

   // Speed times milliseconds is divided by twice the milliseconds per second.
   localparam int VEL_DIVISOR = 2000;
   localparam int VEL_ROUND   = VEL_DIVISOR / 2;
   localparam int VEL_DIV_W   = DPROD_W - DATA_W;
   localparam int Q16_HALF    = 32768;
   localparam int Q16_ONE     = 65536;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MS     = 2'd2;

   localparam logic [DATA_W-1:0]   PROCESS_NOISE_RST = 32'd655;
   localparam logic [DATA_W-1:0]   MEASURE_NOISE_RST = 32'd65536;
   localparam logic [PERIOD_W-1:0] PERIOD_MS_RST     = 10'd1;
   localparam logic [DATA_W-1:0]   COVARIANCE_RST    = 32'd65536;

   typedef logic [DATA_W-1:0] q16_type;
   typedef logic [MAG_W-1:0]  wide_type;

endpackage

### design/kal1d_mul.sv
// Digit-serial unsigned multiplier: product = a * b + addend, taking two
// bits of b per cycle.
// Stand-alone; no package needed.
module kal1d_mul #(
   parameter int A_W = 33,
   parameter int B_W = 16,
   parameter int P_W = 49
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   input  logic [P_W-1:0] addend,
   output logic           busy,
   output logic [P_W-1:0] product
);

   localparam int NDIG  = (B_W + 1) / 2;
   localparam int BP_W  = 2 * NDIG;
   localparam int CNT_W = $clog2(NDIG + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(NDIG - 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [P_W-1:0]   acc_ff, acc_in;
   logic [P_W-1:0]   mcand_ff, mcand_in;
   logic [BP_W-1:0]  mplier_ff, mplier_in;
   logic [P_W-1:0]   pp_lo, pp_hi;

   always_comb begin
      pp_lo     = mplier_ff[0] ? mcand_ff : '0;
      pp_hi     = mplier_ff[1] ? {mcand_ff[P_W-2:0], 1'b0} : '0;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acc_in    = addend;
         mcand_in  = P_W'(a);
         mplier_in = BP_W'(b);
      end else if (busy_ff) begin
         // The multiplicand moves up one digit as the multiplier moves down.
         acc_in    = acc_ff + pp_lo + pp_hi;
         mcand_in  = {mcand_ff[P_W-3:0], 2'b00};
         mplier_in = {2'b00, mplier_ff[BP_W-1:2]};
         cnt_in    = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;

endmodule

### design/kal1d_vdiv.sv
// Radix-4 restoring divider by the fixed velocity divisor; two quotient
// bits per cycle.
// Depends on kal1d_pkg for widths and the divisor.
module kal1d_vdiv
   import kal1d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DPROD_W-1:0] dividend,
   output logic               busy,
   output logic [DATA_W-1:0]  quotient
);

   localparam int NSTEP = DATA_W / 2;
   localparam int CNT_W = $clog2(NSTEP + 1);
   localparam logic [CNT_W-1:0]   LAST = CNT_W'(NSTEP - 1);
   localparam logic [VEL_DIV_W:0] DIVISOR_X = (VEL_DIV_W + 1)'(VEL_DIVISOR);

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [VEL_DIV_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0]    low_ff, low_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [VEL_DIV_W:0]   try_hi, try_lo, sub_hi, sub_lo;
   logic                 ge_hi, ge_lo;
   logic [VEL_DIV_W-1:0] rem_mid;

   always_comb begin
      try_hi  = {rem_ff, low_ff[DATA_W-1]};
      ge_hi   = try_hi >= DIVISOR_X;
      sub_hi  = try_hi - DIVISOR_X;
      rem_mid = ge_hi ? sub_hi[VEL_DIV_W-1:0] : try_hi[VEL_DIV_W-1:0];
      try_lo  = {rem_mid, low_ff[DATA_W-2]};
      ge_lo   = try_lo >= DIVISOR_X;
      sub_lo  = try_lo - DIVISOR_X;

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         // The upper bits of the dividend are always below the divisor.
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[DPROD_W-1:DATA_W];
         low_in  = dividend[DATA_W-1:0];
      end else if (busy_ff) begin
         rem_in = ge_lo ? sub_lo[VEL_DIV_W-1:0] : try_lo[VEL_DIV_W-1:0];
         low_in = {low_ff[DATA_W-3:0], 2'b00};
         quo_in = {quo_ff[DATA_W-3:0], ge_hi, ge_lo};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### design/kal1d_gdiv.sv
// Bit-serial gain divider: gain = floor(p * 2^16 / (p + r)), clamped to
// the Q0.16 range, one quotient bit per cycle.
// Depends on kal1d_pkg for widths.
module kal1d_gdiv
   import kal1d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] p,
   input  logic [DATA_W-1:0] r,
   output logic              busy,
   output logic [GAIN_W-1:0] gain
);

   localparam int CNT_W = $clog2(GAIN_W + 1);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(GAIN_W - 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [MAG_W-1:0]  den_ff, den_in;
   logic [MAG_W-1:0]  rem_ff, rem_in;
   logic [GAIN_W-1:0] quo_ff, quo_in;
   logic              rzero_ff, rzero_in, pzero_ff, pzero_in;
   logic [MAG_W:0]    try_rem, sub_rem;
   logic              ge;

   always_comb begin
      try_rem  = {rem_ff, 1'b0};
      ge       = try_rem >= {1'b0, den_ff};
      sub_rem  = try_rem - {1'b0, den_ff};
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      rzero_in = rzero_ff;
      pzero_in = pzero_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         den_in   = {1'b0, p} + {1'b0, r};
         rem_in   = {1'b0, p};
         rzero_in = (r == '0);
         pzero_in = (p == '0);
      end else if (busy_ff) begin
         rem_in = ge ? sub_rem[MAG_W-1:0] : try_rem[MAG_W-1:0];
         quo_in = {quo_ff[GAIN_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      rzero_ff <= rzero_in;
      pzero_ff <= pzero_in;
   end

   // With zero measurement noise the quotient reaches one and is clamped,
   // unless the divisor itself is zero, which gives no gain at all.
   always_comb begin
      if (rzero_ff) begin
         gain = pzero_ff ? '0 : '1;
      end else begin
         gain = quo_ff;
      end
   end

   assign busy = busy_ff;

endmodule

### design/kalman_1d_velocity_aided.sv
// Top level of the velocity-aided scalar Kalman filter: handshakes, state,
// sequencer and the digit-serial arithmetic units.
// Depends on kal1d_pkg, kal1d_mul, kal1d_vdiv and kal1d_gdiv.
//
//   channel  direction  transfer          payload
//   req_     in         tvalid & tready   tdata: measurement, velocity
//   rsp_     out        tvalid & tready   tdata: estimate
//   csr_     in         valid & ready     index, data (register write)
//
// An estimate is offered after the delta multiply, the velocity division, the
// covariance multiply and the sequencer steps, and the next item may follow
// once it is offered; the gain divider runs beside the delta path. Reset is
// synchronous and active high; it loads the register defaults, a zero estimate
// and speed, and a covariance of one.
// A new item is taken while the last estimate waits; a stalled result
// channel holds only the final update step.
module kalman_1d_velocity_aided
   import kal1d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // [31:0] measurement, [63:32] velocity
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // [31:0] estimate
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] ST_PREP  = 4'd1;
   localparam logic [ST_W-1:0] ST_DMUL  = 4'd2;
   localparam logic [ST_W-1:0] ST_CDIV  = 4'd3;
   localparam logic [ST_W-1:0] ST_PRED  = 4'd4;
   localparam logic [ST_W-1:0] ST_DIFF  = 4'd5;
   localparam logic [ST_W-1:0] ST_KWAIT = 4'd6;
   localparam logic [ST_W-1:0] ST_CMUL  = 4'd7;
   localparam logic [ST_W-1:0] ST_EST   = 4'd8;

   // Clamp a value with two guard bits to the signed 32-bit range.
   function automatic q16_type sat_q16(input logic [DATA_W+1:0] v);
      logic [2:0] top;
      top = v[DATA_W+1:DATA_W-1];
      if (top == 3'b000 || top == 3'b111) begin
         sat_q16 = v[DATA_W-1:0];
      end else if (v[DATA_W+1]) begin
         sat_q16 = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         sat_q16 = {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   // Two's complement negate when neg is set; also serves as magnitude.
   function automatic wide_type cond_neg(input wide_type x, input logic neg);
      cond_neg = (x ^ {MAG_W{neg}}) + MAG_W'(neg);
   endfunction

   // Configuration registers.
   q16_type             q_noise_ff, r_noise_ff;
   logic [PERIOD_W-1:0] period_ff;

   // Filter state; est_ff doubles as the output register.
   q16_type  est_ff, est_in;
   q16_type  cov_ff, cov_in;
   q16_type  prev_vel_ff, prev_vel_in;

   logic [ST_W-1:0] state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Per-item working registers.
   q16_type  meas_ff, meas_in, vel_ff, vel_in;
   q16_type  p_ff, p_in;
   q16_type  pred_ff, pred_in;
   wide_type sum_ff, sum_in;
   wide_type delta_ff, delta_in;
   wide_type diff_ff, diff_in;
   wide_type corr_ff, corr_in;
   logic     sign_ff, sign_in;

   logic               req_xfer, rsp_free;
   logic [MAG_W:0]     p_sum;
   logic               dmul_start, dmul_busy;
   logic [DPROD_W-1:0] dmul_prod;
   logic               vdiv_start, vdiv_busy;
   q16_type            vdiv_quo;
   logic               gdiv_busy;
   logic [GAIN_W-1:0]  gain;
   logic               cmul_start, cmul_busy, pmul_busy;
   logic [CPROD_W-1:0] cmul_prod;
   logic [PPROD_W-1:0] pmul_prod;
   logic [GAIN_W:0]    one_minus_gain;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = est_ff;

   // Configuration writes; an index past the last register is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_noise_ff <= PROCESS_NOISE_RST;
         r_noise_ff <= MEASURE_NOISE_RST;
         period_ff  <= PERIOD_MS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PROCESS_NOISE: q_noise_ff <= csr_data;
            CSR_MEASURE_NOISE: r_noise_ff <= csr_data;
            CSR_PERIOD_MS:     period_ff  <= csr_data[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   assign p_sum          = {1'b0, cov_ff} + {1'b0, q_noise_ff};
   assign dmul_start     = (state_ff == ST_PREP);
   assign vdiv_start     = (state_ff == ST_DMUL) && !dmul_busy;
   assign cmul_start     = (state_ff == ST_KWAIT) && !gdiv_busy;
   assign one_minus_gain = (GAIN_W + 1)'(Q16_ONE) - {1'b0, gain};

   // Sequencer. The delta path is multiply, divide, then the predicted
   // position; the gain divider starts with it and is awaited before the
   // correction and covariance multiplies, which run side by side.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      est_in       = est_ff;
      cov_in       = cov_ff;
      prev_vel_in  = prev_vel_ff;
      meas_in      = meas_ff;
      vel_in       = vel_ff;
      p_in         = p_ff;
      pred_in      = pred_ff;
      sum_in       = sum_ff;
      delta_in     = delta_ff;
      diff_in      = diff_ff;
      corr_in      = corr_ff;
      sign_in      = sign_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               meas_in  = req_tdata[DATA_W-1:0];
               vel_in   = req_tdata[2*DATA_W-1:DATA_W];
               sum_in   = {prev_vel_ff[DATA_W-1], prev_vel_ff}
                        + {req_tdata[2*DATA_W-1], req_tdata[2*DATA_W-1:DATA_W]};
               p_in     = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            sign_in  = sum_ff[MAG_W-1];
            state_in = ST_DMUL;
         end
         ST_DMUL: begin
            if (!dmul_busy) begin
               state_in = ST_CDIV;
            end
         end
         ST_CDIV: begin
            if (!vdiv_busy) begin
               delta_in = cond_neg({1'b0, vdiv_quo}, sign_ff);
               state_in = ST_PRED;
            end
         end
         ST_PRED: begin
            pred_in  = sat_q16({{2{est_ff[DATA_W-1]}}, est_ff}
                             + {delta_ff[MAG_W-1], delta_ff});
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = {meas_ff[DATA_W-1], meas_ff} - {pred_ff[DATA_W-1], pred_ff};
            state_in = ST_KWAIT;
         end
         ST_KWAIT: begin
            if (!gdiv_busy) begin
               sign_in  = diff_ff[MAG_W-1];
               state_in = ST_CMUL;
            end
         end
         ST_CMUL: begin
            if (!cmul_busy && !pmul_busy) begin
               corr_in  = cond_neg(cmul_prod[CPROD_W-1:GAIN_W], sign_ff);
               cov_in   = pmul_prod[DATA_W+GAIN_W-1:GAIN_W];
               state_in = ST_EST;
            end
         end
         ST_EST: begin
            // The estimate register is also the result register, so it
            // only moves once the previous result has been taken.
            if (rsp_free) begin
               est_in       = sat_q16({{2{pred_ff[DATA_W-1]}}, pred_ff}
                                    + {corr_ff[MAG_W-1], corr_ff});
               prev_vel_in  = vel_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         est_ff       <= '0;
         cov_ff       <= COVARIANCE_RST;
         prev_vel_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         prev_vel_ff  <= prev_vel_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff  <= meas_in;
      vel_ff   <= vel_in;
      p_ff     <= p_in;
      pred_ff  <= pred_in;
      sum_ff   <= sum_in;
      delta_ff <= delta_in;
      diff_ff  <= diff_in;
      corr_ff  <= corr_in;
      sign_ff  <= sign_in;
   end

   // Speed sum times period, plus half the divisor for rounding.
   kal1d_mul #(
      .A_W (MAG_W),
      .B_W (PERIOD_W),
      .P_W (DPROD_W)
   ) u_dmul (
      .clock   (clock),
      .reset   (reset),
      .start   (dmul_start),
      .a       (cond_neg(sum_ff, sum_ff[MAG_W-1])),
      .b       (period_ff),
      .addend  (DPROD_W'(VEL_ROUND)),
      .busy    (dmul_busy),
      .product (dmul_prod)
   );

   kal1d_vdiv u_vdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (vdiv_start),
      .dividend (dmul_prod),
      .busy     (vdiv_busy),
      .quotient (vdiv_quo)
   );

   kal1d_gdiv u_gdiv (
      .clock (clock),
      .reset (reset),
      .start (dmul_start),
      .p     (p_ff),
      .r     (r_noise_ff),
      .busy  (gdiv_busy),
      .gain  (gain)
   );

   // Innovation magnitude times gain, rounded at the Q16 point.
   kal1d_mul #(
      .A_W (MAG_W),
      .B_W (GAIN_W),
      .P_W (CPROD_W)
   ) u_cmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmul_start),
      .a       (cond_neg(diff_ff, diff_ff[MAG_W-1])),
      .b       (gain),
      .addend  (CPROD_W'(Q16_HALF)),
      .busy    (cmul_busy),
      .product (cmul_prod)
   );

   // Covariance scaled by one minus the gain, rounded at the Q16 point.
   kal1d_mul #(
      .A_W (DATA_W),
      .B_W (GAIN_W + 1),
      .P_W (PPROD_W)
   ) u_pmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmul_start),
      .a       (p_ff),
      .b       (one_minus_gain),
      .addend  (PPROD_W'(Q16_HALF)),
      .busy    (pmul_busy),
      .product (pmul_prod)
   );

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_PREP))
      else $error("accepted item did not start the sequencer");

   a_gain_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMUL) |-> !gdiv_busy)
      else $error("gain used while its divider is still running");

   a_est_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EST && rsp_valid_ff && !rsp_tready) |=>
         (state_ff == ST_EST) && $stable(est_ff))
      else $error("estimate updated while the previous result was pending");
`endif

endmodule
